[design/rmtm_pkg.sv]
`default_nettype none
package rmtm_pkg;

   localparam int SAMPLE_W = 16;

   // configuration register indexes
   localparam logic [0:0] REG_TRIM_LOW  = 1'd0;
   localparam logic [0:0] REG_TRIM_HIGH = 1'd1;

   // sorter operation codes
   localparam logic [1:0] SORT_HOLD   = 2'd0;
   localparam logic [1:0] SORT_REFILL = 2'd1;
   localparam logic [1:0] SORT_REMOVE = 2'd2;
   localparam logic [1:0] SORT_INSERT = 2'd3;

   // one queued item
   typedef struct packed {
      logic                       refill;
      logic signed [SAMPLE_W-1:0] sample;
   } cmd_type;

   // sorter control
   typedef struct packed {
      logic [1:0]                 op;
      logic signed [SAMPLE_W-1:0] value;
   } sort_ctl_type;

endpackage
`default_nettype wire

[design/rmtm_queue.sv]
`default_nettype none
module rmtm_queue (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire rmtm_pkg::cmd_type push_data,
   output logic                  full,
   input  wire logic             pop,
   output logic                  head_valid,
   output rmtm_pkg::cmd_type     head_data
);
   import rmtm_pkg::*;

   cmd_type    entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   assign full       = (count_ff == 2'd2);
   assign head_valid = (count_ff != 2'd0);
   assign head_data  = entry_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   // pointer and fill update
   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // item storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

[design/rmtm_sorter.sv]
`default_nettype none
module rmtm_sorter #(
   parameter int W = 16
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire rmtm_pkg::sort_ctl_type        ctl,
   input  wire logic [$clog2(W)-1:0]          slot,
   output logic [W-1:0][rmtm_pkg::SAMPLE_W-1:0] vals
);
   import rmtm_pkg::*;

   localparam int IDX_W = $clog2(W);

   logic signed [SAMPLE_W-1:0] val_ff [W];
   logic signed [SAMPLE_W-1:0] val_in [W];
   logic [IDX_W-1:0]           tag_ff [W];
   logic [IDX_W-1:0]           tag_in [W];
   logic [W-1:0]               match;
   logic [W-1:0]               at_or_above;
   logic [W-1:0]               below_new;

   // locate the entry of the slot being replaced and the rank of the new value
   always_comb begin
      for (int i = 0; i < W; i++) begin
         match[i] = (tag_ff[i] == slot);
         below_new[i] = (i < W - 1) ? (val_ff[i] < ctl.value) : 1'b0;
      end
      at_or_above[0] = match[0];
      for (int i = 1; i < W; i++) begin
         at_or_above[i] = at_or_above[i-1] | match[i];
      end
   end

   // per cell next value
   always_comb begin
      for (int i = 0; i < W; i++) begin
         val_in[i] = val_ff[i];
         tag_in[i] = tag_ff[i];
         case (ctl.op)
            SORT_REFILL: begin
               val_in[i] = ctl.value;
               tag_in[i] = IDX_W'(i);
            end
            SORT_REMOVE: begin
               // close the gap left by the removed entry, hole ends at the top
               if (i < W - 1 && at_or_above[i]) begin
                  val_in[i] = val_ff[(i < W - 1) ? i + 1 : i];
                  tag_in[i] = tag_ff[(i < W - 1) ? i + 1 : i];
               end
            end
            SORT_INSERT: begin
               // cells below the new rank keep, the rank cell takes it, above shift up
               if (!below_new[i]) begin
                  if (i == 0 || below_new[(i > 0) ? i - 1 : 0]) begin
                     val_in[i] = ctl.value;
                     tag_in[i] = slot;
                  end else begin
                     val_in[i] = val_ff[(i > 0) ? i - 1 : 0];
                     tag_in[i] = tag_ff[(i > 0) ? i - 1 : 0];
                  end
               end
            end
            default: begin
               val_in[i] = val_ff[i];
               tag_in[i] = tag_ff[i];
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < W; i++) begin
            val_ff[i] <= '0;
            tag_ff[i] <= IDX_W'(i);
         end
      end else begin
         for (int i = 0; i < W; i++) begin
            val_ff[i] <= val_in[i];
            tag_ff[i] <= tag_in[i];
         end
      end
   end

   always_comb begin
      for (int i = 0; i < W; i++) begin
         vals[i] = val_ff[i];
      end
   end

endmodule
`default_nettype wire

[design/rmtm_divider.sv]
`default_nettype none
module rmtm_divider #(
   parameter int SUM_W = 20,
   parameter int CNT_W = 5
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   input  wire logic signed [SUM_W-1:0]      dividend,
   input  wire logic [CNT_W-1:0]             divisor,
   output logic                              done,
   output logic signed [rmtm_pkg::SAMPLE_W-1:0] quotient
);
   import rmtm_pkg::*;

   localparam int STEP_W = $clog2(SUM_W + 1);

   logic [SUM_W-1:0]  quo_ff, quo_in;
   logic [CNT_W-1:0]  rem_ff, rem_in;
   logic [CNT_W-1:0]  div_ff, div_in;
   logic              neg_ff, neg_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CNT_W:0]    rem_shift;
   logic [CNT_W:0]    diff;
   logic [SUM_W-1:0]  neg_quo;

   // one quotient bit per cycle, restoring on the magnitude
   always_comb begin
      rem_shift = {rem_ff, quo_ff[SUM_W-1]};
      diff      = rem_shift - {1'b0, div_ff};
      quo_in    = quo_ff;
      rem_in    = rem_ff;
      div_in    = div_ff;
      neg_in    = neg_ff;
      step_in   = step_ff;
      busy_in   = busy_ff;
      done_in   = 1'b0;
      if (start) begin
         neg_in  = dividend[SUM_W-1];
         quo_in  = dividend[SUM_W-1] ? SUM_W'(-dividend) : dividend;
         rem_in  = '0;
         div_in  = divisor;
         step_in = STEP_W'(SUM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!diff[CNT_W]) begin
            rem_in = diff[CNT_W-1:0];
            quo_in = {quo_ff[SUM_W-2:0], 1'b1};
         end else begin
            rem_in = rem_shift[CNT_W-1:0];
            quo_in = {quo_ff[SUM_W-2:0], 1'b0};
         end
         step_in = step_ff - STEP_W'(1);
         if (step_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
      neg_ff <= neg_in;
   end

   // sign restored, truncation toward zero
   assign neg_quo  = -quo_ff;
   assign done     = done_ff;
   assign quotient = neg_ff ? neg_quo[SAMPLE_W-1:0] : quo_ff[SAMPLE_W-1:0];

endmodule
`default_nettype wire

[design/running_median_trimmed_mean.sv]
`default_nettype none
// channel | direction | handshake              | payload
// req     | in        | req_tvalid/req_tready  | tdata: sample; tuser: mode
// rsp     | out       | rsp_tvalid/rsp_tready  | tdata: median, trimmed_mean; tuser: trim_error
// csr     | in        | csr_we                 | csr_addr, csr_wdata
//
// In the back end, a refill skips the insert step; n is the number of untrimmed
// ranks (WINDOW - trim_low - trim_high), which are summed serially before the
// one-bit-a-cycle divider runs. An error item skips the sum and the divider.
// Reset is synchronous and leaves the window all zero. A two-entry queue takes
// items while the back end works; the result register holds a finished item
// while the next one is already in progress.
module running_median_trimmed_mean #(
   parameter int WINDOW = 16
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [15:0]  req_tdata,   // [15:0] sample
   input  wire logic [0:0]   req_tuser,   // [0] mode
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [31:0]       rsp_tdata,   // [15:0] median, [31:16] trimmed_mean
   output logic [0:0]        rsp_tuser,   // [0] trim_error
   input  wire logic         csr_we,
   input  wire logic [0:0]   csr_addr,
   input  wire logic [3:0]   csr_wdata
);
   import rmtm_pkg::*;

   localparam int IDX_W = $clog2(WINDOW);
   localparam int CNT_W = $clog2(WINDOW + 1);
   localparam int SUM_W = SAMPLE_W + $clog2(WINDOW);
   localparam int CMP_W = ((CNT_W > 5) ? CNT_W : 5) + 1;
   localparam int MID   = WINDOW / 2;
   localparam bit ODD   = (WINDOW % 2) != 0;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_INSERT = 3'd1;
   localparam logic [2:0] ST_STAT   = 3'd2;
   localparam logic [2:0] ST_SUM    = 3'd3;
   localparam logic [2:0] ST_DIVGO  = 3'd4;
   localparam logic [2:0] ST_DIV    = 3'd5;
   localparam logic [2:0] ST_HOLD   = 3'd6;

   // configuration registers
   logic [3:0] trim_low_ff, trim_high_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         trim_low_ff  <= '0;
         trim_high_ff <= '0;
      end else if (csr_we) begin
         case (csr_addr)
            REG_TRIM_LOW:  trim_low_ff  <= csr_wdata;
            REG_TRIM_HIGH: trim_high_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // front: accept and queue items
   cmd_type push_cmd, head_cmd;
   logic    q_full, q_valid, q_pop;

   assign push_cmd.refill = req_tuser[0];
   assign push_cmd.sample = req_tdata;
   assign req_tready      = !q_full;

   rmtm_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (req_tvalid),
      .push_data  (push_cmd),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head_data  (head_cmd)
   );

   // back: sorted window
   sort_ctl_type                     sort_ctl;
   logic [WINDOW-1:0][SAMPLE_W-1:0] vals;
   logic [IDX_W-1:0]                 oldest_ff, oldest_in;

   rmtm_sorter #(.W(WINDOW)) u_sorter (
      .clock (clock),
      .reset (reset),
      .ctl   (sort_ctl),
      .slot  (oldest_ff),
      .vals  (vals)
   );

   // back: divider
   logic                       div_start, div_done;
   logic signed [SAMPLE_W-1:0] div_quo;
   logic signed [SUM_W-1:0]    acc_ff, acc_in;
   logic [CNT_W-1:0]           cnt_ff, cnt_in;
   logic [CNT_W-1:0]           total_ff, total_in;

   rmtm_divider #(.SUM_W(SUM_W), .CNT_W(CNT_W)) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (acc_ff),
      .divisor  (total_ff),
      .done     (div_done),
      .quotient (div_quo)
   );

   // median from the middle ranks, floor average for an even window
   logic signed [SAMPLE_W:0]   mid_sum;
   logic signed [SAMPLE_W-1:0] median_now;

   assign mid_sum    = {vals[MID][SAMPLE_W-1], vals[MID]}
                     + {vals[(MID > 0) ? MID - 1 : 0][SAMPLE_W-1],
                        vals[(MID > 0) ? MID - 1 : 0]};
   assign median_now = ODD ? vals[MID] : mid_sum[SAMPLE_W:1];

   // trim checks
   logic [CMP_W-1:0] trim_total, rank_count;
   logic             trim_err;

   assign trim_total = CMP_W'(trim_low_ff) + CMP_W'(trim_high_ff);
   assign trim_err   = trim_total >= CMP_W'(WINDOW);
   assign rank_count = CMP_W'(WINDOW) - trim_total;

   // back sequencer
   logic [2:0]                 state_ff, state_in;
   logic signed [SAMPLE_W-1:0] sample_ff, sample_in;
   logic [IDX_W-1:0]           idx_ff, idx_in;
   logic signed [SAMPLE_W-1:0] median_ff, median_in;
   logic signed [SAMPLE_W-1:0] mean_ff, mean_in;
   logic                       err_ff, err_in;
   logic signed [SAMPLE_W-1:0] rank_val;
   logic                       out_free;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [31:0]                rsp_data_ff, rsp_data_in;
   logic                       rsp_err_ff, rsp_err_in;

   assign rank_val = vals[idx_ff];
   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in     = state_ff;
      sample_in    = sample_ff;
      oldest_in    = oldest_ff;
      idx_in       = idx_ff;
      cnt_in       = cnt_ff;
      total_in     = total_ff;
      acc_in       = acc_ff;
      median_in    = median_ff;
      mean_in      = mean_ff;
      err_in       = err_ff;
      q_pop        = 1'b0;
      div_start    = 1'b0;
      sort_ctl.op    = SORT_HOLD;
      sort_ctl.value = sample_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_err_in   = rsp_err_ff;
      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_pop          = 1'b1;
               sample_in      = head_cmd.sample;
               sort_ctl.value = head_cmd.sample;
               if (head_cmd.refill) begin
                  sort_ctl.op = SORT_REFILL;
                  oldest_in   = '0;
                  state_in    = ST_STAT;
               end else begin
                  sort_ctl.op = SORT_REMOVE;
                  state_in    = ST_INSERT;
               end
            end
         end
         ST_INSERT: begin
            sort_ctl.op = SORT_INSERT;
            oldest_in   = (oldest_ff == IDX_W'(WINDOW - 1)) ? '0 : oldest_ff + IDX_W'(1);
            state_in    = ST_STAT;
         end
         ST_STAT: begin
            median_in = median_now;
            err_in    = trim_err;
            mean_in   = '0;
            acc_in    = '0;
            idx_in    = IDX_W'(trim_low_ff);
            cnt_in    = CNT_W'(rank_count);
            total_in  = CNT_W'(rank_count);
            state_in  = trim_err ? ST_HOLD : ST_SUM;
         end
         ST_SUM: begin
            // one rank per cycle
            acc_in = acc_ff + SUM_W'(rank_val);
            idx_in = idx_ff + IDX_W'(1);
            cnt_in = cnt_ff - CNT_W'(1);
            if (cnt_ff == CNT_W'(1)) begin
               state_in = ST_DIVGO;
            end
         end
         ST_DIVGO: begin
            div_start = 1'b1;
            state_in  = ST_DIV;
         end
         ST_DIV: begin
            if (div_done) begin
               mean_in  = div_quo;
               state_in = ST_HOLD;
            end
         end
         ST_HOLD: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {mean_ff, median_ff};
               rsp_err_in   = err_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         oldest_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         oldest_ff    <= oldest_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      sample_ff   <= sample_in;
      idx_ff      <= idx_in;
      total_ff    <= total_in;
      acc_ff      <= acc_in;
      median_ff   <= median_in;
      mean_ff     <= mean_in;
      err_ff      <= err_in;
      rsp_data_ff <= rsp_data_in;
      rsp_err_ff  <= rsp_err_in;
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_data_ff;
   assign rsp_tuser[0] = rsp_err_ff;

   // checks
   a_err_mean_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata[31:16] == 16'd0)
      else $error("trim error with nonzero mean");

   a_sum_count: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SUM |-> cnt_ff != '0)
      else $error("rank sum ran past its count");

   a_div_done_state: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == ST_DIV)
      else $error("divider finished outside its wait state");

endmodule
`default_nettype wire

[tb/sv/tb_running_median_trimmed_mean.sv]
`default_nettype none
module tb_running_median_trimmed_mean;
   import rmtm_pkg::*;

   localparam int WIN = 16;
   localparam int N_RANDOM = 1830;

   typedef enum logic {MODE_INSERT = 1'b0, MODE_REFILL = 1'b1} mode_e;

   typedef struct packed {
      logic signed [15:0] median;
      logic signed [15:0] mean;
      logic               trim_err;
   } stat_t;

   typedef struct {
      mode_e              mode;
      logic signed [15:0] sample;
      logic               has_known;
      stat_t              known;
   } step_row_t;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [15:0] req_tdata;   // [15:0] sample
   logic [0:0]  req_tuser;   // [0] mode
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;   // [15:0] median, [31:16] trimmed_mean
   logic [0:0]  rsp_tuser;   // [0] trim_error
   logic        csr_we;
   logic [0:0]  csr_addr;
   logic [3:0]  csr_wdata;

   running_median_trimmed_mean #(.WINDOW(WIN)) u_dut (.*);

   // predictor state
   logic signed [15:0] win_age [WIN];
   logic signed [15:0] rank_val [WIN];
   logic [3:0]         rank_tag [WIN];
   logic [3:0]         oldest;
   logic [3:0]         cut_low, cut_high;

   stat_t stats_pending [$];
   int    n_fail, n_items, n_results;
   bit    no_idle;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #20000000;
      $display("timeout");
      $display("simulation failed");
      $finish;
   end

   function automatic void window_refill(input logic signed [15:0] v);
      for (int i = 0; i < WIN; i++) begin
         win_age[i] = v;
         rank_val[i] = v;
         rank_tag[i] = 4'(i);
      end
      oldest = '0;
   endfunction

   // advance the window by one item and return median and trimmed mean
   function automatic stat_t window_update(input mode_e mode, input logic signed [15:0] v);
      stat_t r;
      int p, s, sum, stop;
      logic signed [15:0] tv;
      logic [3:0] tt;
      p = 0;
      if (mode == MODE_REFILL) window_refill(v);
      else begin
         for (int i = WIN - 1; i >= 0; i--) if (rank_tag[i] == oldest) p = i;
         win_age[oldest] = v;
         rank_val[p] = v;
         while (p + 1 < WIN && rank_val[p] > rank_val[p+1]) begin
            tv = rank_val[p]; tt = rank_tag[p];
            rank_val[p] = rank_val[p+1]; rank_tag[p] = rank_tag[p+1];
            rank_val[p+1] = tv; rank_tag[p+1] = tt;
            p++;
         end
         while (p > 0 && rank_val[p] < rank_val[p-1]) begin
            tv = rank_val[p]; tt = rank_tag[p];
            rank_val[p] = rank_val[p-1]; rank_tag[p] = rank_tag[p-1];
            rank_val[p-1] = tv; rank_tag[p-1] = tt;
            p--;
         end
         oldest = oldest + 4'd1;
      end
      // floor average of the two middle ranks
      s = int'(rank_val[WIN/2]) + int'(rank_val[WIN/2-1]);
      r.median = 16'(s >>> 1);
      r.mean = '0;
      r.trim_err = 1'b0;
      if (int'(cut_low) + int'(cut_high) >= WIN) r.trim_err = 1'b1;
      else begin
         sum = 0;
         stop = WIN - int'(cut_high);
         for (int i = cut_low; i < stop; i++) sum += rank_val[i];
         r.mean = 16'(sum / (stop - int'(cut_low)));
      end
      return r;
   endfunction

   task automatic idle_burst();
      repeat ($urandom_range(1, 5)) @(posedge clock);
   endtask

   // one item through the request channel, with its prediction queued
   task automatic send_item(input mode_e mode, input logic signed [15:0] v,
                            input bit has_known, input stat_t known);
      stat_t e;
      if (!no_idle && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         idle_burst();
      end
      e = window_update(mode, v);
      if (has_known && e != known) begin
         $display("%0t table row disagrees: table %h predictor %h", $time, known, e);
         n_fail++;
      end
      stats_pending.push_back(e);
      req_tvalid <= 1'b1;
      req_tdata <= v;
      req_tuser <= mode;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      n_items++;
   endtask

   task automatic drain(input int settle);
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (stats_pending.size() != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   task automatic write_reg(input logic [0:0] idx, input logic [3:0] val);
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      if (idx == REG_TRIM_LOW) cut_low = val;
      else cut_high = val;
   endtask

   function automatic stat_t mk(input logic signed [15:0] m, input logic signed [15:0] a,
                                input logic e);
      stat_t r;
      r.median = m; r.mean = a; r.trim_err = e;
      return r;
   endfunction

   // result side: random stalls and in-order compare
   initial begin
      stat_t e;
      rsp_tready = 1'b0;
      @(negedge reset);
      forever begin
         if (!no_idle && $urandom_range(0, 3) == 0) begin
            rsp_tready <= 1'b0;
            idle_burst();
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) begin
            n_results++;
            if (stats_pending.size() == 0) begin
               $display("%0t unexpected item: actual %h/%h err %b", $time,
                        rsp_tdata[15:0], rsp_tdata[31:16], rsp_tuser[0]);
               n_fail++;
            end else begin
               e = stats_pending.pop_front();
               if (rsp_tdata[15:0] !== e.median) begin
                  $display("%0t median mismatch: expected %0d actual %0d", $time,
                           e.median, $signed(rsp_tdata[15:0]));
                  n_fail++;
               end
               if (rsp_tdata[31:16] !== e.mean) begin
                  $display("%0t trimmed_mean mismatch: expected %0d actual %0d", $time,
                           e.mean, $signed(rsp_tdata[31:16]));
                  n_fail++;
               end
               if (rsp_tuser[0] !== e.trim_err) begin
                  $display("%0t trim_error mismatch: expected %b actual %b", $time,
                           e.trim_err, rsp_tuser[0]);
                  n_fail++;
               end
            end
         end
      end
   end

   // stimulus
   initial begin
      step_row_t rows [$];
      stat_t none;
      logic [3:0] lo, hi;
      logic signed [15:0] v;
      int base;
      none = '0;
      n_fail = 0; n_items = 0; n_results = 0; no_idle = 0;
      reset = 1'b1;
      req_tvalid = 1'b0; req_tdata = '0; req_tuser = '0;
      csr_we = 1'b0; csr_addr = '0; csr_wdata = '0;
      window_refill(16'sd0);
      cut_low = '0; cut_high = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table: insert one into zeros, extremes by refill, ramp
      rows.push_back('{MODE_INSERT, 16'sd5, 1'b1, mk(16'sd0, 16'sd0, 1'b0)});
      rows.push_back('{MODE_REFILL, 16'sh7fff, 1'b1, mk(16'sh7fff, 16'sh7fff, 1'b0)});
      rows.push_back('{MODE_REFILL, -16'sh8000, 1'b1, mk(-16'sh8000, -16'sh8000, 1'b0)});
      rows.push_back('{MODE_REFILL, -16'sd1, 1'b1, mk(-16'sd1, -16'sd1, 1'b0)});
      rows.push_back('{MODE_INSERT, 16'sh7fff, 1'b0, none});
      rows.push_back('{MODE_INSERT, -16'sh8000, 1'b0, none});
      for (int i = 0; i < 14; i++)
         rows.push_back('{MODE_INSERT, 16'(i * 2341 - 15000), 1'b0, none});
      rows.push_back('{MODE_INSERT, 16'sh5555, 1'b0, none});
      rows.push_back('{MODE_INSERT, -16'sh5556, 1'b0, none});
      foreach (rows[i]) send_item(rows[i].mode, rows[i].sample, rows[i].has_known,
                                  rows[i].known);

      // trim extremes, including the error case on a refilled window
      drain(60);
      write_reg(REG_TRIM_LOW, 4'd15);
      write_reg(REG_TRIM_HIGH, 4'd15);
      send_item(MODE_REFILL, 16'sd100, 1'b1, mk(16'sd100, 16'sd0, 1'b1));
      send_item(MODE_INSERT, -16'sd7, 1'b0, none);
      drain(60);
      write_reg(REG_TRIM_LOW, 4'd15);
      write_reg(REG_TRIM_HIGH, 4'd0);
      send_item(MODE_INSERT, 16'sd9, 1'b0, none);
      drain(60);
      write_reg(REG_TRIM_LOW, 4'd0);
      write_reg(REG_TRIM_HIGH, 4'd15);
      send_item(MODE_INSERT, -16'sd9, 1'b0, none);

      // random phases, each with new trims
      for (int ph = 0; ph < 12; ph++) begin
         drain(60);
         lo = 4'($urandom_range(0, 15));
         hi = 4'($urandom_range(0, 15));
         if (ph % 3 != 2) begin
            lo = 4'($urandom_range(0, 7));
            hi = 4'($urandom_range(0, 7));
         end
         write_reg(REG_TRIM_LOW, lo);
         write_reg(REG_TRIM_HIGH, hi);
         if (ph >= 10) no_idle = 1;
         for (int k = 0; k < N_RANDOM / 12; k++) begin
            if (k == 70) drain(0);
            base = $urandom_range(0, 3);
            case (base)
               0: v = 16'($urandom);
               1: v = 16'($urandom_range(0, 40)) - 16'sd20;
               2: v = $urandom_range(0, 1) ? 16'sh7fff : -16'sh8000;
               default: v = 16'($urandom_range(0, 2000)) - 16'sd1000;
            endcase
            send_item($urandom_range(0, 39) == 0 ? MODE_REFILL : MODE_INSERT, v,
                      1'b0, none);
         end
      end

      drain(200);
      $display("covered %0d items and %0d results over 15 trim settings", n_items,
               n_results);
      $display("inserts, refills, sample extremes and trim overflow exercised");
      if (n_fail == 0) $display("simulation ok");
      else $display("simulation failed");
      $finish;
   end

endmodule
`default_nettype wire

[running_median_trimmed_mean.f]
design/rmtm_pkg.sv
design/rmtm_queue.sv
design/rmtm_sorter.sv
design/rmtm_divider.sv
design/running_median_trimmed_mean.sv
tb/sv/tb_running_median_trimmed_mean.sv
